/* design/lsb_stego_payload_extractor_assert.svh */
// Assertion macros used by the extractor's parser module (clk and rst_n taken from scope)
`ifndef LSB_STEGO_PAYLOAD_EXTRACTOR_ASSERT_SVH
`define LSB_STEGO_PAYLOAD_EXTRACTOR_ASSERT_SVH

// Same-cycle implication, disabled while in reset
`define LSBSPE_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while in reset
`define LSBSPE_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* design/lsbspe_pkg.sv */
// Package: types, codes and constants of the LSB payload extractor
`timescale 1ns / 1ps
package lsbspe_pkg;

  localparam int unsigned MAX_MAGIC_BYTES = 8;
  localparam logic [7:0]  HEADER_SKIP_RST = 8'd54;
  localparam logic [3:0]  MAGIC_LEN_RST   = 4'd2;
  localparam logic [3:0]  MAGIC_LEN_MAX   = 4'(MAX_MAGIC_BYTES);
  localparam logic [31:0] LEN_BYTES       = 32'd4;

  // Configuration register indexes
  localparam logic [1:0] CFG_HEADER_SKIP  = 2'd0;
  localparam logic [1:0] CFG_MAGIC_LENGTH = 2'd1;
  localparam logic [1:0] CFG_MAGIC_VALUE  = 2'd2;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_EXT     = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_ERROR   = 2'd2,
    KIND_LENGTH  = 2'd3
  } kind_t;

  // Parse phases, one-hot
  typedef enum logic [7:0] {
    PH_HEADER  = 8'b0000_0001,
    PH_MAGIC   = 8'b0000_0010,
    PH_EXTLEN  = 8'b0000_0100,
    PH_EXT     = 8'b0000_1000,
    PH_LEN     = 8'b0001_0000,
    PH_PAYLOAD = 8'b0010_0000,
    PH_DONE    = 8'b0100_0000,
    PH_ERROR   = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    logic [7:0]  header_skip;
    logic [3:0]  magic_length;
    logic [63:0] magic_value;
  } cfg_t;

  typedef struct packed {
    logic        valid;
    kind_t       kind;
    logic [7:0]  data;
    logic [31:0] length;
    logic        last;
  } result_t;

endpackage

/* design/lsb_stego_payload_extractor.sv */
// Top level: input register, configuration registers, parser and result register
`timescale 1ns / 1ps
// LSB steganography payload extractor.
// Input channel (in_valid / in_stall): one cover image byte per transfer, with
// in_start_of_image marking the first byte of a new image and restarting the parse.
// Result channel (out_valid / out_stall): at most one result per image byte:
// extension byte, payload byte (out_last on the final one), signature mismatch,
// or the payload length (out_last when it is zero).
// Configuration: write cfg_wdata to register cfg_index when cfg_we is high;
// header skip, signature length and signature value. Write only while idle.
// Throughput: one image byte per cycle while the receiver does not stall, set by
// the combinational parse step between the input register and the result register.
// A byte's result is loaded into the result register when the parse step takes the
// byte from the input register, and stays there until it is taken.
// Reset (rst_n low, synchronous) empties both registers, restores the default
// configuration (skip 54, two signature bytes, signature zero) and the parse.
// When the receiver stalls, the result register holds; the input register takes
// one more byte if it is empty, then in_stall rises until the result is taken.
module lsb_stego_payload_extractor (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_image_byte,
  input  logic                  in_start_of_image,
  output logic                  out_valid,
  input  logic                  out_stall,
  output lsbspe_pkg::kind_t     out_kind,
  output logic [7:0]            out_byte,
  output logic [31:0]           out_payload_length,
  output logic                  out_last,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [63:0]           cfg_wdata
);
  import lsbspe_pkg::*;

  cfg_t    cfg_r, cfg_nxt;
  logic    in_valid_r, in_valid_nxt;
  logic [7:0] img_r;
  logic    sof_r;
  logic    out_valid_r, out_valid_nxt;
  result_t res;
  result_t res_r;
  logic    go;

  // Process the held byte whenever the result slot is free or draining
  assign go       = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !go;

  // Configuration register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_HEADER_SKIP:  cfg_nxt.header_skip  = cfg_wdata[7:0];
        CFG_MAGIC_LENGTH: cfg_nxt.magic_length = cfg_wdata[3:0];
        CFG_MAGIC_VALUE:  cfg_nxt.magic_value  = cfg_wdata;
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_skip  <= HEADER_SKIP_RST;
      cfg_r.magic_length <= MAGIC_LEN_RST;
      cfg_r.magic_value  <= 64'd0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Input register: take a new transfer whenever not stalled
  assign in_valid_nxt = in_stall ? in_valid_r : in_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      img_r <= in_image_byte;
      sof_r <= in_start_of_image;
    end
  end

  lsbspe_parser u_parser (
    .clk            (clk),
    .rst_n          (rst_n),
    .go             (go),
    .image_byte     (img_r),
    .start_of_image (sof_r),
    .cfg            (cfg_r),
    .res            (res)
  );

  // Result register: load a new result, drop a taken one
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (go && res.valid) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go && res.valid) begin
      res_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_kind           = res_r.kind;
  assign out_byte           = res_r.data;
  assign out_payload_length = res_r.length;
  assign out_last           = res_r.last;

endmodule

/* design/lsbspe_parser.sv */
// Parser: header skip, LSB byte assembly and field decode, one image byte per go
`timescale 1ns / 1ps
module lsbspe_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                go,
  input  logic [7:0]          image_byte,
  input  logic                start_of_image,
  input  lsbspe_pkg::cfg_t    cfg,
  output lsbspe_pkg::result_t res
);
  import lsbspe_pkg::*;

  phase_t      phase_r,    phase_nxt;
  logic [2:0]  bit_pos_r,  bit_pos_nxt;
  logic [7:0]  byte_acc_r, byte_acc_nxt;
  logic [7:0]  hdr_cnt_r,  hdr_cnt_nxt;
  logic [31:0] fld_cnt_r,  fld_cnt_nxt;
  logic [7:0]  ext_len_r,  ext_len_nxt;
  logic [31:0] len_acc_r,  len_acc_nxt;

  logic [3:0]  magic_eff;

  // Clamp signature length to the supported maximum
  assign magic_eff = (cfg.magic_length > MAGIC_LEN_MAX) ? MAGIC_LEN_MAX : cfg.magic_length;

  // Decode one image byte
  always_comb begin
    logic        skip;
    logic [7:0]  b;
    logic [7:0]  expect_byte;
    logic [31:0] cnt_inc;
    logic [31:0] len_new;

    phase_nxt    = phase_r;
    bit_pos_nxt  = bit_pos_r;
    byte_acc_nxt = byte_acc_r;
    hdr_cnt_nxt  = hdr_cnt_r;
    fld_cnt_nxt  = fld_cnt_r;
    ext_len_nxt  = ext_len_r;
    len_acc_nxt  = len_acc_r;
    res          = '0;
    skip         = 1'b0;
    b            = 8'd0;
    expect_byte  = 8'd0;
    cnt_inc      = 32'd0;
    len_new      = 32'd0;

    // Restart the parse on a new image
    if (start_of_image) begin
      phase_nxt    = PH_HEADER;
      bit_pos_nxt  = 3'd0;
      byte_acc_nxt = 8'd0;
      hdr_cnt_nxt  = 8'd0;
      fld_cnt_nxt  = 32'd0;
      ext_len_nxt  = 8'd0;
      len_acc_nxt  = 32'd0;
    end

    // Count off header bytes, then fall through into the data phases
    if (phase_nxt == PH_HEADER) begin
      if (hdr_cnt_nxt < cfg.header_skip) begin
        hdr_cnt_nxt = hdr_cnt_nxt + 8'd1;
        skip        = 1'b1;
      end else begin
        fld_cnt_nxt = 32'd0;
        phase_nxt   = (magic_eff == 4'd0) ? PH_EXTLEN : PH_MAGIC;
      end
    end

    if (phase_nxt == PH_DONE || phase_nxt == PH_ERROR) begin
      skip = 1'b1;
    end

    if (!skip) begin
      // Gather bit 0, first bit in the low position
      byte_acc_nxt = byte_acc_nxt | (8'(image_byte[0]) << bit_pos_nxt);
      if (bit_pos_nxt != 3'd7) begin
        bit_pos_nxt = bit_pos_nxt + 3'd1;
      end else begin
        b            = byte_acc_nxt;
        byte_acc_nxt = 8'd0;
        bit_pos_nxt  = 3'd0;
        cnt_inc      = fld_cnt_nxt + 32'd1;
        expect_byte  = cfg.magic_value[{fld_cnt_nxt[2:0], 3'b000} +: 8];
        len_new      = len_acc_nxt | (32'(b) << {fld_cnt_nxt[1:0], 3'b000});

        case (phase_nxt)
          PH_MAGIC: begin
            if (b != expect_byte) begin
              phase_nxt = PH_ERROR;
              res.valid = 1'b1;
              res.kind  = KIND_ERROR;
            end else if (cnt_inc >= 32'(magic_eff)) begin
              fld_cnt_nxt = 32'd0;
              phase_nxt   = PH_EXTLEN;
            end else begin
              fld_cnt_nxt = cnt_inc;
            end
          end
          PH_EXTLEN: begin
            ext_len_nxt = b;
            fld_cnt_nxt = 32'd0;
            len_acc_nxt = 32'd0;
            phase_nxt   = (b != 8'd0) ? PH_EXT : PH_LEN;
          end
          PH_EXT: begin
            if (cnt_inc >= 32'(ext_len_nxt)) begin
              fld_cnt_nxt = 32'd0;
              len_acc_nxt = 32'd0;
              phase_nxt   = PH_LEN;
            end else begin
              fld_cnt_nxt = cnt_inc;
            end
            res.valid = 1'b1;
            res.kind  = KIND_EXT;
            res.data  = b;
          end
          PH_LEN: begin
            len_acc_nxt = len_new;
            if (cnt_inc >= LEN_BYTES) begin
              fld_cnt_nxt = 32'd0;
              res.valid   = 1'b1;
              res.kind    = KIND_LENGTH;
              res.length  = len_new;
              if (len_new == 32'd0) begin
                phase_nxt = PH_DONE;
                res.last  = 1'b1;
              end else begin
                phase_nxt = PH_PAYLOAD;
              end
            end else begin
              fld_cnt_nxt = cnt_inc;
            end
          end
          PH_PAYLOAD: begin
            fld_cnt_nxt = cnt_inc;
            res.valid   = 1'b1;
            res.kind    = KIND_PAYLOAD;
            res.data    = b;
            res.last    = (cnt_inc >= len_acc_nxt);
            if (cnt_inc >= len_acc_nxt) begin
              phase_nxt = PH_DONE;
            end
          end
          default: begin
            phase_nxt = phase_nxt;
          end
        endcase
      end
    end

    // Hold everything unless a byte is being taken
    if (!go) begin
      phase_nxt    = phase_r;
      bit_pos_nxt  = bit_pos_r;
      byte_acc_nxt = byte_acc_r;
      hdr_cnt_nxt  = hdr_cnt_r;
      fld_cnt_nxt  = fld_cnt_r;
      ext_len_nxt  = ext_len_r;
      len_acc_nxt  = len_acc_r;
      res.valid    = 1'b0;
    end
  end

  // Parse state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HEADER;
      bit_pos_r  <= 3'd0;
      byte_acc_r <= 8'd0;
      hdr_cnt_r  <= 8'd0;
      fld_cnt_r  <= 32'd0;
      ext_len_r  <= 8'd0;
      len_acc_r  <= 32'd0;
    end else begin
      phase_r    <= phase_nxt;
      bit_pos_r  <= bit_pos_nxt;
      byte_acc_r <= byte_acc_nxt;
      hdr_cnt_r  <= hdr_cnt_nxt;
      fld_cnt_r  <= fld_cnt_nxt;
      ext_len_r  <= ext_len_nxt;
      len_acc_r  <= len_acc_nxt;
    end
  end

  `include "lsb_stego_payload_extractor_assert.svh"

  `LSBSPE_ASSERT_IMP(a_idle_bitpos, (phase_r == PH_HEADER || phase_r == PH_DONE || phase_r == PH_ERROR), bit_pos_r == 3'd0)
  `LSBSPE_ASSERT_NXT(a_last_done, go && res.valid && res.kind == KIND_PAYLOAD && res.last, phase_r == PH_DONE)
  `LSBSPE_ASSERT_IMP(a_payload_len, phase_r == PH_PAYLOAD, len_acc_r != 32'd0)
  `LSBSPE_ASSERT_IMP(a_ext_bound, phase_r == PH_EXT, fld_cnt_r < 32'(ext_len_r))

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for the LSB steganography payload extractor
`timescale 1ns / 1ps
module tb;
  import lsbspe_pkg::*;

  localparam int unsigned LIMIT_CYCLES   = 400000;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned STAGE_ITEMS    = 200;
  localparam int unsigned LAST_STAGE     = 5;
  localparam int unsigned PRESSURE_STAGE = 1;
  localparam int unsigned PRINT_CAP      = 100;
  // index with no register behind it
  localparam logic [1:0]  CFG_SPARE      = 2'd3;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct {
    logic [7:0] img;
    logic       sos;
  } cover_byte_t;

  typedef struct {
    kind_t       kind;
    logic [7:0]  data;
    logic [31:0] length;
    logic        last;
  } hidden_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_image_byte;
  logic        in_start_of_image;
  logic        out_valid;
  logic        out_stall;
  kind_t       out_kind;
  logic [7:0]  out_byte;
  logic [31:0] out_payload_length;
  logic        out_last;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_wdata;

  lsb_stego_payload_extractor dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_image_byte      (in_image_byte),
    .in_start_of_image  (in_start_of_image),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_byte           (out_byte),
    .out_payload_length (out_payload_length),
    .out_last           (out_last),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  // Stimulus and expectation stores
  cover_byte_t    image_stream [$];
  hidden_result_t results_due [$];
  logic           sos_next = 1'b0;

  // Run control
  logic [31:0]    cycles = '0;
  int unsigned    mismatches = 0;
  int unsigned    stage = 0;
  idle_mode_t     mode = IDLE_NONE;
  int unsigned    hold_left = 0;
  bit             pressure_done = 1'b0;

  // Decoder copy of the configuration
  logic [7:0]  cfg_skip  = HEADER_SKIP_RST;
  logic [3:0]  cfg_mlen  = MAGIC_LEN_RST;
  logic [63:0] cfg_magic = '0;

  // Decoder copy of the parse state
  phase_t      dec_phase   = PH_HEADER;
  logic [2:0]  dec_bitpos  = '0;
  logic [7:0]  dec_acc     = '0;
  logic [7:0]  dec_hdr     = '0;
  logic [31:0] dec_field   = '0;
  logic [7:0]  dec_ext_len = '0;
  logic [31:0] dec_len     = '0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [3:0] signature_len();
    return (cfg_mlen > MAGIC_LEN_MAX) ? MAGIC_LEN_MAX : cfg_mlen;
  endfunction

  // Decide whether one side idles this cycle
  function automatic bit holds_back(bit receiver_side);
    if (mode == IDLE_BOTH)
      return $urandom_range(0, 99) < 29;
    if (receiver_side)
      return (mode == IDLE_RECEIVER) && ($urandom_range(0, 99) < 85);
    return (mode == IDLE_SENDER) && ($urandom_range(0, 99) < 85);
  endfunction

  task automatic report(input string msg);
    if (mismatches < PRINT_CAP)
      $display("[cycle %0d] mismatch: %s", cycles, msg);
    mismatches++;
  endtask

  // Advance the decoder by one cover byte and record any result it gives
  task automatic decode_image_byte(input logic [7:0] img, input logic sos);
    logic [7:0] hb;
    logic [7:0] sig;
    logic       fin;
    if (sos) begin
      dec_phase   = PH_HEADER;
      dec_bitpos  = '0;
      dec_acc     = '0;
      dec_hdr     = '0;
      dec_field   = '0;
      dec_ext_len = '0;
      dec_len     = '0;
    end
    if (dec_phase == PH_HEADER) begin
      if (dec_hdr < cfg_skip) begin
        dec_hdr = dec_hdr + 8'd1;
        return;
      end
      dec_field = '0;
      dec_phase = (signature_len() == 0) ? PH_EXTLEN : PH_MAGIC;
    end
    if (dec_phase == PH_DONE || dec_phase == PH_ERROR)
      return;
    dec_acc[dec_bitpos] = img[0];
    if (dec_bitpos != 3'd7) begin
      dec_bitpos = dec_bitpos + 3'd1;
      return;
    end
    hb         = dec_acc;
    dec_acc    = '0;
    dec_bitpos = '0;
    case (dec_phase)
      PH_MAGIC: begin
        sig = cfg_magic[8 * dec_field[2:0] +: 8];
        if (hb != sig) begin
          dec_phase = PH_ERROR;
          results_due.push_back('{KIND_ERROR, 8'h00, 32'h0, 1'b0});
        end else begin
          dec_field = dec_field + 1;
          if (dec_field >= 32'(signature_len())) begin
            dec_field = '0;
            dec_phase = PH_EXTLEN;
          end
        end
      end
      PH_EXTLEN: begin
        dec_ext_len = hb;
        dec_field   = '0;
        dec_len     = '0;
        dec_phase   = (hb != 8'd0) ? PH_EXT : PH_LEN;
      end
      PH_EXT: begin
        dec_field = dec_field + 1;
        if (dec_field >= 32'(dec_ext_len)) begin
          dec_field = '0;
          dec_len   = '0;
          dec_phase = PH_LEN;
        end
        results_due.push_back('{KIND_EXT, hb, 32'h0, 1'b0});
      end
      PH_LEN: begin
        dec_len   = dec_len | (32'(hb) << (8 * dec_field[1:0]));
        dec_field = dec_field + 1;
        if (dec_field >= LEN_BYTES) begin
          dec_field = '0;
          if (dec_len == 32'd0) begin
            dec_phase = PH_DONE;
            results_due.push_back('{KIND_LENGTH, 8'h00, 32'h0, 1'b1});
          end else begin
            dec_phase = PH_PAYLOAD;
            results_due.push_back('{KIND_LENGTH, 8'h00, dec_len, 1'b0});
          end
        end
      end
      PH_PAYLOAD: begin
        dec_field = dec_field + 1;
        fin       = (dec_field >= dec_len);
        if (fin)
          dec_phase = PH_DONE;
        results_due.push_back('{KIND_PAYLOAD, hb, 32'h0, fin});
      end
      default: ;
    endcase
  endtask

  task automatic queue_raw(input logic [7:0] img);
    image_stream.push_back('{img: img, sos: sos_next});
    sos_next = 1'b0;
  endtask

  // Spread one hidden byte over eight cover bytes, first bit first
  task automatic queue_hidden_byte(input logic [7:0] b, input bit extremes);
    for (int k = 0; k < 8; k++)
      queue_raw(extremes ? {8{b[k]}} : {7'($urandom), b[k]});
  endtask

  // Build one cover image: mostly well-formed, some corrupt, cut short or pure noise
  task automatic queue_image(inout int unsigned data_items);
    logic [7:0]  hidden [$];
    logic [7:0]  sig;
    logic [7:0]  ext_len;
    logic [31:0] plen;
    int unsigned n_sig;
    int unsigned bad_at;
    int unsigned keep;
    int unsigned pick;
    int          start_n;
    start_n = image_stream.size();
    n_sig = signature_len();
    keep  = 0;
    pick  = $urandom_range(0, 99);
    if (pick < 8) begin
      repeat ($urandom_range(1, 12)) hidden.push_back(8'($urandom));
    end else begin
      bad_at = (pick < 20) ? $urandom_range(0, 7) : 8;
      for (int i = 0; i < n_sig; i++) begin
        sig = cfg_magic[8 * i +: 8];
        if (i == bad_at)
          sig ^= 8'($urandom_range(1, 255));
        hidden.push_back(sig);
      end
      pick = $urandom_range(0, 9);
      if (pick == 0)
        ext_len = 8'($urandom_range(5, 255));
      else if (pick < 3)
        ext_len = 8'd0;
      else
        ext_len = 8'($urandom_range(1, 4));
      hidden.push_back(ext_len);
      repeat (ext_len) hidden.push_back(8'($urandom));
      // long extensions keep only a random number of hidden bytes, at most n_sig + 12
      if (pick == 0)
        keep = $urandom_range(1, n_sig + 12);
      pick = $urandom_range(0, 9);
      if (pick < 2)
        plen = 32'd0;
      else if (pick == 2)
        plen = $urandom;
      else
        plen = $urandom_range(1, 6);
      for (int i = 0; i < 4; i++)
        hidden.push_back(plen[8 * i +: 8]);
      if (pick == 2)
        repeat ($urandom_range(0, 5)) hidden.push_back(8'($urandom));
      else
        repeat (plen) hidden.push_back(8'($urandom));
      if (keep == 0 && $urandom_range(0, 9) == 0)
        keep = $urandom_range(1, hidden.size());
    end
    if (keep != 0 && keep < hidden.size())
      hidden = hidden[0:keep - 1];
    sos_next = ($urandom_range(0, 9) != 0);
    repeat (cfg_skip) queue_raw(8'($urandom));
    foreach (hidden[i])
      queue_hidden_byte(hidden[i], 1'b0);
    repeat ($urandom_range(0, 3)) queue_raw(8'($urandom));
    // count every cover byte of this image, header and tail included
    data_items += unsigned'(image_stream.size() - start_n);
  endtask

  // Write one register and mirror it in the decoder copy
  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_HEADER_SKIP:  cfg_skip  = val[7:0];
      CFG_MAGIC_LENGTH: cfg_mlen  = val[3:0];
      CFG_MAGIC_VALUE:  cfg_magic = val;
      default: ;
    endcase
  endtask

  // Hold until every queued byte is taken and every result has come, then let the pipe drain
  task automatic wait_quiet();
    while (image_stream.size() != 0 || in_valid || results_due.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Sender: predict each transfer, then offer the next byte unless idling
  always @(posedge clk) begin : drive_bytes
    cover_byte_t nxt;
    if (rst_n) begin
      if (in_valid && !in_stall)
        decode_image_byte(in_image_byte, in_start_of_image);
      if (!in_valid || !in_stall) begin
        if (image_stream.size() != 0 && !holds_back(1'b0)) begin
          nxt = image_stream.pop_front();
          in_valid          <= 1'b1;
          in_image_byte     <= nxt.img;
          in_start_of_image <= nxt.sos;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off to back the block up
  always @(posedge clk) begin : drive_stall
    if (stage == PRESSURE_STAGE && !pressure_done) begin
      hold_left     = HOLD_CYCLES;
      pressure_done = 1'b1;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= holds_back(1'b1);
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin : check_results
    hidden_result_t want;
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb failed");
      $finish;
    end else if (rst_n && out_valid && !out_stall) begin
      if (results_due.size() == 0) begin
        report($sformatf("result kind %0d with nothing expected", out_kind));
      end else begin
        want = results_due.pop_front();
        if (out_kind !== want.kind)
          report($sformatf("kind got %0d want %0d", out_kind, want.kind));
        if (out_byte !== want.data)
          report($sformatf("byte got %h want %h", out_byte, want.data));
        if (out_payload_length !== want.length)
          report($sformatf("length got %h want %h", out_payload_length, want.length));
        if (out_last !== want.last)
          report($sformatf("last got %b want %b", out_last, want.last));
      end
    end
  end

  initial begin : run_test
    int unsigned data_items;
    logic [7:0]  skip;
    logic [3:0]  mlen;
    logic [63:0] mval;
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_image_byte     = '0;
    in_start_of_image = 1'b0;
    out_stall         = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = CFG_HEADER_SKIP;
    cfg_wdata         = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: no header, one signature byte against the reset signature of zero
    write_reg(CFG_HEADER_SKIP, {$urandom, 24'($urandom), 8'd0});
    write_reg(CFG_MAGIC_LENGTH, {$urandom, 28'($urandom), 4'd1});
    @(negedge clk);
    sos_next = 1'b1;
    queue_hidden_byte(8'h5A, 1'b1);
    queue_raw(8'hFF);
    queue_raw(8'h00);
    sos_next = 1'b1;
    queue_hidden_byte(8'h00, 1'b0);

    // Random stages, each with its own settings and an idling mode
    for (int s = 1; s <= LAST_STAGE; s++) begin
      wait_quiet();
      case (s)
        1: begin skip = 8'd54;  mlen = 4'd2;  mval = {$urandom, $urandom}; end
        2: begin skip = 8'd0;   mlen = 4'd0;  mval = {$urandom, $urandom}; end
        3: begin skip = 8'd255; mlen = 4'd8;  mval = '1;                   end
        4: begin skip = 8'($urandom_range(1, 20)); mlen = 4'd15; mval = {$urandom, $urandom}; end
        default: begin skip = 8'd7; mlen = 4'd9; mval = '0; end
      endcase
      write_reg(CFG_HEADER_SKIP, {$urandom, 24'($urandom), skip});
      write_reg(CFG_MAGIC_LENGTH, {$urandom, 28'($urandom), mlen});
      write_reg(CFG_MAGIC_VALUE, mval);
      if (s == 1)
        write_reg(CFG_SPARE, {$urandom, $urandom});
      @(negedge clk);
      case (s)
        2:       mode = IDLE_SENDER;
        3:       mode = IDLE_RECEIVER;
        4:       mode = IDLE_BOTH;
        default: mode = IDLE_NONE;
      endcase
      stage      = s;
      data_items = 0;
      while (data_items < STAGE_ITEMS)
        queue_image(data_items);
    end

    wait_quiet();
    if (mismatches == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end

endmodule
